>>> src/ltfr_pkg.sv
// Shared types and constants for the LED trail frame renderer.
`default_nettype none

package ltfr_pkg;

    localparam int NUM_LEDS = 10;
    localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    localparam int COLOR_W  = 8;
    localparam int WORD_W   = 3 * COLOR_W;
    localparam int SPAN_W   = 6;              // 3 * trail_length, up to 45
    localparam int K_W      = 8;              // 9 * trail_length, up to 135
    localparam int SUB_W    = 7;              // position + span - 1, up to 75
    localparam int QBITS    = 7;              // scale quotient never exceeds 85
    localparam int Q_MAX    = 85;
    localparam int CNT_W    = 3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [4:0] position;
        logic [3:0] trail_length;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic [3:0]  led_index;
        logic [23:0] bit_word;
        logic        last;
    } pixel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DIV,
        S_MUL,
        S_WR,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

`default_nettype wire

>>> src/ltfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ltfr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/led_trail_frame_renderer_core.sv
// Draw: reduce the start position to (LED, phase), then 6L - 1 trail steps; L = 0 draws nothing.
// Each trail step costs 7 divider iterations, 3 multiplies (one per channel) and a write.
// Emit: per LED word a RAM read, then an output load that waits while the output is stalled; NUM_LEDS transactions.
// One item at a time; item_stall is high until the current item is finished.
// Reset clears the frame through per-LED valid bits; the frame RAM itself is not swept.
`default_nettype none

module led_trail_frame_renderer_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire ltfr_pkg::item_t item,
    output logic                 pixel_valid,
    input  wire logic            pixel_stall,
    output ltfr_pkg::pixel_t     pixel
);

    import ltfr_pkg::*;

    localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

    state_t state_reg, state_next;

    logic [NUM_LEDS-1:0] valid_reg;
    logic                pixel_valid_reg;
    pixel_t              pixel_reg;

    logic [COLOR_W-1:0]  red_reg, green_reg, blue_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [K_W-1:0]      k_reg;
    logic [SUB_W-1:0]    sub_reg;
    logic [LED_W-1:0]    led_reg;
    logic [LED_W-1:0]    n_reg;
    logic [1:0]          phase_reg;
    logic [SPAN_W-1:0]   i_reg;
    logic                desc_reg;
    logic [K_W-1:0]      rem_reg;
    logic [QBITS-1:0]    q_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [1:0]          chan_reg;
    logic [WORD_W-1:0]   acc_reg;

    logic                item_accept;
    logic                pixel_take;
    logic                load_ok;
    logic [SPAN_W-1:0]   span_in;
    logic [K_W-1:0]      k_in;
    logic [SUB_W-1:0]    sub_in;
    logic [LED_W-1:0]    led_inc;
    logic [LED_W-1:0]    led_dec;
    logic [K_W:0]        rem_shift;
    logic                div_ge;
    logic [K_W-1:0]      rem_new;
    logic                step_done;
    logic [SPAN_W-1:0]   i_next;
    logic                desc_next;
    logic [WORD_W-1:0]   old_word;
    logic [COLOR_W-1:0]  color_sel;
    logic [COLOR_W-1:0]  old_byte;
    logic [COLOR_W+QBITS-1:0] prod;
    logic [COLOR_W-1:0]  new_byte;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [LED_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    // ---------------------------------------------------------------- datapath
    assign item_accept = item_valid && !item_stall;
    assign pixel_take  = pixel_valid_reg && !pixel_stall;
    assign load_ok     = !pixel_valid_reg || pixel_take;

    assign span_in = SPAN_W'({2'b00, item.trail_length}) + SPAN_W'({1'b0, item.trail_length, 1'b0});
    assign k_in    = K_W'({item.trail_length, 3'b000}) + K_W'(item.trail_length);
    assign sub_in  = SUB_W'(item.position) + SUB_W'(span_in) - SUB_W'(1);

    assign led_inc = (led_reg == LED_LAST) ? '0 : led_reg + LED_W'(1);
    assign led_dec = (led_reg == '0) ? LED_LAST : led_reg - LED_W'(1);

    // restoring divider: one quotient bit per cycle, dividend low bits are all zero
    assign rem_shift = {rem_reg, 1'b0};
    assign div_ge    = rem_shift >= {1'b0, k_reg};
    assign rem_new   = div_ge ? K_W'(rem_shift - {1'b0, k_reg}) : K_W'(rem_shift);

    assign step_done = desc_reg && (i_reg == SPAN_W'(1));
    assign i_next    = desc_reg ? i_reg - SPAN_W'(1) : i_reg + SPAN_W'(1);
    assign desc_next = desc_reg || ((i_reg + SPAN_W'(1)) == span_reg);

    assign old_word = valid_reg[led_reg] ? ram_rd_data : '0;

    always_comb
    begin
        case (chan_reg)
            CH_RED:
            begin
                color_sel = red_reg;
                old_byte  = old_word[23:16];
            end
            CH_GREEN:
            begin
                color_sel = green_reg;
                old_byte  = old_word[15:8];
            end
            default:
            begin
                color_sel = blue_reg;
                old_byte  = old_word[7:0];
            end
        endcase
    end

    assign prod     = (COLOR_W+QBITS)'(color_sel) * (COLOR_W+QBITS)'(q_reg);
    assign new_byte = old_byte + COLOR_W'(prod[COLOR_W+QBITS-1:COLOR_W]);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (item.cmd == CMD_EMIT)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else if (item.trail_length != '0)
                    begin
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (sub_reg < SUB_W'(3))
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(QBITS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (chan_reg == CH_BLUE)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                state_next = step_done ? S_IDLE : S_DIV;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (load_ok)
                begin
                    state_next = (n_reg == LED_LAST) ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        item_stall  = 1'b1;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = led_reg;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
            end
            S_DIV:
            begin
                ram_rd_en = (cnt_reg == '0);
            end
            S_WR:
            begin
                ram_wr_en = 1'b1;
            end
            S_EMIT_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = n_reg;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WR)
            begin
                valid_reg[led_reg] <= 1'b1;
            end
            else if (state_reg == S_EMIT_LD && load_ok && n_reg == LED_LAST)
            begin
                valid_reg <= '0;
            end
            if (state_reg == S_EMIT_LD && load_ok)
            begin
                pixel_valid_reg <= 1'b1;
            end
            else if (pixel_take)
            begin
                pixel_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    red_reg   <= item.red;
                    green_reg <= item.green;
                    blue_reg  <= item.blue;
                    span_reg  <= span_in;
                    k_reg     <= k_in;
                    sub_reg   <= sub_in;
                    led_reg   <= '0;
                    n_reg     <= '0;
                    i_reg     <= SPAN_W'(1);
                    desc_reg  <= 1'b0;
                end
            end
            S_REDUCE:
            begin
                // start sub-pixel reduced to (LED, phase); LED wraps around the ring
                if (sub_reg >= SUB_W'(3))
                begin
                    sub_reg <= sub_reg - SUB_W'(3);
                    led_reg <= led_inc;
                end
                else
                begin
                    phase_reg <= sub_reg[1:0];
                    rem_reg   <= K_W'({i_reg, 1'b0});
                    cnt_reg   <= '0;
                end
            end
            S_DIV:
            begin
                rem_reg  <= rem_new;
                q_reg    <= {q_reg[QBITS-2:0], div_ge};
                cnt_reg  <= cnt_reg + CNT_W'(1);
                chan_reg <= CH_RED;
            end
            S_MUL:
            begin
                case (chan_reg)
                    CH_RED:   acc_reg[23:16] <= new_byte;
                    CH_GREEN: acc_reg[15:8]  <= new_byte;
                    default:  acc_reg[7:0]   <= new_byte;
                endcase
                chan_reg <= chan_reg + 2'd1;
            end
            S_WR:
            begin
                // trail walks the ring downward one sub-pixel per step
                i_reg    <= i_next;
                desc_reg <= desc_next;
                rem_reg  <= K_W'({i_next, 1'b0});
                cnt_reg  <= '0;
                if (phase_reg == 2'd0)
                begin
                    phase_reg <= 2'd2;
                    led_reg   <= led_dec;
                end
                else
                begin
                    phase_reg <= phase_reg - 2'd1;
                end
            end
            S_EMIT_LD:
            begin
                if (load_ok)
                begin
                    pixel_reg.led_index <= 4'(n_reg);
                    pixel_reg.bit_word  <= valid_reg[n_reg] ? ram_rd_data : '0;
                    pixel_reg.last      <= (n_reg == LED_LAST);
                    n_reg               <= n_reg + LED_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    ltfr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_LEDS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (led_reg),
        .wr_data (acc_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- assertions
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < k_reg)
        else $error("divider remainder not below divisor");

    a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> q_reg <= QBITS'(Q_MAX))
        else $error("trail scale out of range");

    a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> (i_reg != '0) && (i_reg <= span_reg))
        else $error("trail step index out of range");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && load_ok && n_reg == LED_LAST)
            |=> (valid_reg == '0) && pixel_valid_reg && pixel_reg.last)
        else $error("frame not cleared after final word");

endmodule

`default_nettype wire

>>> test/led_trail_frame_renderer_core_tb.sv
// Self-checking testbench for the LED trail frame renderer core.
module led_trail_frame_renderer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ltfr_pkg::*;

    localparam int RING_SUBS   = 3 * NUM_LEDS;
    localparam int ITEM_TARGET = 320;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 1200;      // longer than the longest draw takes
    localparam int REPORT_MAX  = 10;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    item_t  item_bus = '0;
    logic   pixel_valid;
    logic   pixel_stall = 1'b0;
    pixel_t pixel_bus;

    logic [7:0] frame_rgb [NUM_LEDS][3];
    pixel_t     pending_pixels [$];
    int         error_count = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    bit         tx_burst = 1'b0;
    bit         rx_burst = 1'b0;

    led_trail_frame_renderer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item_bus),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int ring_led(int sub);
        int m;
        m = sub % RING_SUBS;
        if (m < 0)
            m += RING_SUBS;
        return m / 3;
    endfunction

    function automatic void add_step(int led, int i, int k, logic [7:0] rgb [3]);
        int scale;
        int part;
        int c;
        scale = (i * 256) / k;
        for (c = 0; c < 3; c++)
        begin
            part = (int'(rgb[c]) * scale) >> 8;
            frame_rgb[led][c] = frame_rgb[led][c] + part[7:0];
        end
    endfunction

    function automatic void add_trail(int pos, int len, logic [7:0] rgb [3]);
        int k;
        int span;
        int i;
        if (len == 0)
            return;
        k    = len * 9;
        span = len * 3;
        for (i = 1; i < span; i++)
            add_step(ring_led(pos + span - i), i, k, rgb);
        for (i = span; i >= 1; i--)
            add_step(ring_led(pos + i - span), i, k, rgb);
    endfunction

    function automatic void emit_frame();
        pixel_t px;
        int n;
        int c;
        for (n = 0; n < NUM_LEDS; n++)
        begin
            px.led_index = n[3:0];
            px.bit_word  = {frame_rgb[n][0], frame_rgb[n][1], frame_rgb[n][2]};
            px.last      = (n == NUM_LEDS - 1);
            pending_pixels.push_back(px);
            for (c = 0; c < 3; c++)
                frame_rgb[n][c] = 8'd0;
        end
    endfunction

    function automatic void apply_item(item_t it);
        logic [7:0] rgb [3];
        if (it.cmd == CMD_EMIT)
            emit_frame();
        else
        begin
            rgb[0] = it.red;
            rgb[1] = it.green;
            rgb[2] = it.blue;
            add_trail(int'(it.position), int'(it.trail_length), rgb);
        end
    endfunction

    function automatic void clear_frame();
        int n;
        int c;
        for (n = 0; n < NUM_LEDS; n++)
            for (c = 0; c < 3; c++)
                frame_rgb[n][c] = 8'd0;
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic item_t draw_item(int pos, int len, int r, int g, int b);
        item_t it;
        it.cmd          = CMD_DRAW;
        it.position     = pos[4:0];
        it.trail_length = len[3:0];
        it.red          = r[7:0];
        it.green        = g[7:0];
        it.blue         = b[7:0];
        return it;
    endfunction

    function automatic int rand_color();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        else if (pick == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    function automatic int rand_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 0;
        else if (pick < 15)
            return $urandom_range(11, 15);
        else if (pick < 60)
            return $urandom_range(1, 3);
        return $urandom_range(1, 10);
    endfunction

    function automatic item_t rand_draw();
        return draw_item($urandom_range(0, 31), rand_length(),
                         rand_color(), rand_color(), rand_color());
    endfunction

    // emit ignores everything but cmd, so the rest is noise
    function automatic item_t rand_emit();
        item_t it;
        it = draw_item($urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255));
        it.cmd = CMD_EMIT;
        return it;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_item(item_t it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_bus   <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        apply_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // receiver holds off each transaction by a random stall, none in burst mode
    initial
    begin : pixel_sink
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_burst ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                pixel_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            pixel_stall <= 1'b0;
            @(posedge clk);
            while (!pixel_valid)
                @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (pending_pixels.size() == 0)
                flag_error($sformatf("unexpected pixel led %0d word %06h last %0b",
                                     pixel_bus.led_index, pixel_bus.bit_word,
                                     pixel_bus.last));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_bus.led_index !== want.led_index)
                    flag_error($sformatf("led_index exp %0d got %0d",
                                         want.led_index, pixel_bus.led_index));
                if (pixel_bus.bit_word !== want.bit_word)
                    flag_error($sformatf("led %0d bit_word exp %06h got %06h",
                                         want.led_index, want.bit_word,
                                         pixel_bus.bit_word));
                if (pixel_bus.last !== want.last)
                    flag_error($sformatf("led %0d last exp %0b got %0b",
                                         want.led_index, want.last, pixel_bus.last));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // frame is all zero out of reset; emit fields set to all ones
    task automatic test_reset_frame();
        item_t it;
        it     = draw_item(31, 15, 255, 255, 255);
        it.cmd = CMD_EMIT;
        send_item(it);
    endtask

    task automatic test_single_trail();
        item_t it;
        send_item(draw_item(0, 1, 255, 255, 255));
        it     = draw_item(0, 0, 0, 0, 0);
        it.cmd = CMD_EMIT;
        send_item(it);
    endtask

    // last in-range position, past-ring positions, trails longer than the ring
    task automatic test_ring_extremes();
        send_item(draw_item(29, 10, 8'h80, 8'h40, 8'h01));
        send_item(draw_item(31, 15, 8'hff, 8'h00, 8'haa));
        send_item(draw_item(30, 11, 8'h55, 8'hff, 8'h0f));
        send_item(rand_emit());
    endtask

    task automatic test_zero_length();
        send_item(draw_item(5, 0, 255, 255, 255));
        send_item(draw_item(14, 3, 8'hff, 8'h7f, 8'h01));
        send_item(draw_item(20, 0, 8'h12, 8'h34, 8'h56));
        send_item(rand_emit());
    endtask

    // repeated full-scale trails on one spot overflow every channel
    task automatic test_sum_wrap();
        int j;
        for (j = 0; j < 6; j++)
            send_item(draw_item(15, 2, 255, 255, 255));
        send_item(rand_emit());
    endtask

    task automatic test_drain_pause();
        send_item(rand_draw());
        send_item(rand_draw());
        send_item(rand_emit());
        wait_drained();
        send_item(rand_draw());
        wait_drained();
        send_item(rand_emit());
        wait_drained();
    endtask

    task automatic test_random_frames();
        int pick;
        int n_draws;
        int j;
        while (items_sent < ITEM_TARGET)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                n_draws = $urandom_range(0, 6);
                for (j = 0; j < n_draws; j++)
                    send_item(rand_draw());
                send_item(rand_emit());
            end
            else if (pick == 8)
            begin
                send_item(rand_emit());
                send_item(rand_emit());
            end
            else
                for (j = 0; j < 3; j++)
                    send_item($urandom_range(0, 1) ? rand_draw() : rand_emit());
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial
    begin
        clear_frame();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_single_trail();
        test_ring_extremes();
        test_zero_length();
        test_sum_wrap();
        test_drain_pause();
        test_random_frames();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
src/ltfr_pkg.sv
src/ltfr_ram.sv
src/led_trail_frame_renderer_core.sv
test/led_trail_frame_renderer_core_tb.sv
